// ===== rtl/core/cat_pkg.sv =====
// Package: shared constants, types and capacity helpers for the compacting array table.
`timescale 1ns / 1ps
package cat_pkg;
  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_POP       = 3'd1,
    OP_DEL_IDX   = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_ALL   = 3'd4,
    OP_READ      = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_POP     = 3'd2,
    ST_INDEX   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_WRITE,
    CM_ROTATE,
    CM_MARK,
    CM_SWAP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t           mode;
    logic                 mark_all;
    logic                 phase;
    logic [IDX_W-1:0]     sel;
    logic [CNT_W-1:0]     lim;
    logic [WORD_BITS-1:0] value;
  } cell_ctl_t;

  function automatic logic [CNT_W-1:0] cap_grow(input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] c;
    c = {cap, 1'b0};
    if (c > (CNT_W + 1)'(DEPTH)) begin
      return CNT_W'(DEPTH);
    end
    return c[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cap_shrink(input logic [CNT_W-1:0] cap,
                                                  input logic [CNT_W-1:0] cnt);
    logic [CNT_W+1:0] lim;
    logic [CNT_W-1:0] h;
    lim = {cnt, 2'b00};
    h   = cap >> 1;
    if ({2'b00, cap} >= lim) begin
      return (h == '0) ? CNT_W'(1) : h;
    end
    return cap;
  endfunction
endpackage

// ===== rtl/core/cat_cell.sv =====
// One storage cell of the chain: holds a word and a live flag, trades with neighbours.
`timescale 1ns / 1ps
module cat_cell
  import cat_pkg::*;
(
  input  logic                 clk,
  input  logic [IDX_W-1:0]     idx,
  input  cell_ctl_t            ctl,
  input  logic [WORD_BITS-1:0] up_word,
  input  logic                 up_alive,
  input  logic [WORD_BITS-1:0] down_word,
  input  logic                 down_alive,
  output logic [WORD_BITS-1:0] word,
  output logic                 alive
);
  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      CM_HOLD: begin
      end
      CM_WRITE: begin
        if (idx == ctl.sel) word <= ctl.value;
      end
      CM_ROTATE: begin
        word <= up_word;
      end
      CM_MARK: begin
        alive <= ({1'b0, idx} < ctl.lim) &&
                 !(ctl.mark_all ? (word == ctl.value) : (idx == ctl.sel));
      end
      CM_SWAP: begin
        if (idx[0] == ctl.phase) begin
          if (!alive && up_alive) begin
            word  <= up_word;
            alive <= 1'b1;
          end
        end else if (alive && !down_alive) begin
          word  <= down_word;
          alive <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== rtl/core/compacting_array_table.sv =====
// Top level: sequencer and chain of cells for the compacting array table.
//
//  channel | signals                               | direction
//  in      | in_valid/in_ready, operation, value,  | in
//          | position, amount                      |
//  out     | out_valid/out_ready, count, capacity, | out
//          | read_word, status                     |
//
// Append, pop and unused codes go straight to the result state; read runs
// one full rotation of the chain; delete at index runs a mark step, then DEPTH
// odd-even swap phases; delete first/all run a rotation scan, then the mark and
// swap phases if a match is found. One item in flight at a time. Synchronous reset
// empties the table and sets capacity to 1. The result register holds
// until taken; the next item is accepted while it waits.
`timescale 1ns / 1ps
module compacting_array_table
  import cat_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              operation,
  input  logic signed [31:0]      value,
  input  logic [7:0]              position,
  input  logic [8:0]              amount,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [8:0]              count,
  output logic [8:0]              capacity,
  output logic signed [31:0]      read_word,
  output logic [2:0]              status
);
  typedef enum logic [2:0] {S_IDLE, S_ROT, S_MARK, S_SWAP, S_DONE} state_t;

  state_t               state;
  op_t                  op;
  logic [WORD_BITS-1:0] val;
  logic [IDX_W-1:0]     pos;
  logic [IDX_W-1:0]     step;
  logic [IDX_W-1:0]     first;
  logic                 found;
  logic [CNT_W-1:0]     hits;
  logic [CNT_W-1:0]     elem_cnt;
  logic [CNT_W-1:0]     cap_reg;
  logic [WORD_BITS-1:0] rd;
  status_t              st;

  cell_ctl_t            ctl;
  logic [WORD_BITS-1:0] cw [DEPTH];
  logic                 ca [DEPTH];

  logic                 acc;
  logic                 hit;
  logic [CNT_W-1:0]     hits_next;
  logic [CNT_W-1:0]     cnt_next;
  logic                 last;

  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign last      = (step == IDX_W'(DEPTH - 1));
  assign hit       = ({1'b0, step} < elem_cnt) && (cw[0] == val);
  assign hits_next = hits + CNT_W'(hit);
  assign cnt_next  = elem_cnt - ((op == OP_DEL_ALL) ? hits : CNT_W'(1));

  always_comb begin
    ctl          = '0;
    ctl.mode     = CM_HOLD;
    ctl.value    = val;
    ctl.lim      = elem_cnt;
    ctl.phase    = step[0];
    ctl.mark_all = (op == OP_DEL_ALL);
    ctl.sel      = (op == OP_DEL_IDX) ? pos : first;
    unique case (state)
      S_IDLE: begin
        if (acc && (operation == OP_APPEND) && (elem_cnt != CNT_W'(DEPTH))) begin
          ctl.mode  = CM_WRITE;
          ctl.sel   = elem_cnt[IDX_W-1:0];
          ctl.value = value[WORD_BITS-1:0];
        end
      end
      S_ROT:  ctl.mode = CM_ROTATE;
      S_MARK: ctl.mode = CM_MARK;
      S_SWAP: ctl.mode = CM_SWAP;
      S_DONE: ctl.mode = CM_HOLD;
      default: ctl.mode = CM_HOLD;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cat_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(g)),
      .ctl       (ctl),
      .up_word   (cw[(g + 1) % DEPTH]),
      .up_alive  ((g == DEPTH - 1) ? 1'b0 : ca[(g + 1) % DEPTH]),
      .down_word (cw[(g + DEPTH - 1) % DEPTH]),
      .down_alive((g == 0) ? 1'b1 : ca[(g + DEPTH - 1) % DEPTH]),
      .word      (cw[g]),
      .alive     (ca[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      elem_cnt  <= '0;
      cap_reg   <= CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            op    <= op_t'(operation);
            val   <= value[WORD_BITS-1:0];
            pos   <= position;
            step  <= '0;
            hits  <= '0;
            found <= 1'b0;
            first <= '0;
            rd    <= '0;
            st    <= ST_OK;
            state <= S_DONE;
            unique case (operation)
              OP_APPEND: begin
                if (elem_cnt == CNT_W'(DEPTH)) begin
                  st <= ST_FULL;
                end else begin
                  if (elem_cnt >= cap_reg) cap_reg <= cap_grow(cap_reg);
                  elem_cnt <= elem_cnt + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (amount > elem_cnt) begin
                  st <= ST_POP;
                end else begin
                  elem_cnt <= elem_cnt - amount;
                  cap_reg  <= cap_shrink(cap_reg, elem_cnt - amount);
                end
              end
              OP_DEL_IDX: begin
                if ({1'b0, position} >= elem_cnt) st <= ST_INDEX;
                else state <= S_MARK;
              end
              OP_DEL_FIRST, OP_DEL_ALL: state <= S_ROT;
              OP_READ: begin
                if ({1'b0, position} >= elem_cnt) st <= ST_INDEX;
                else state <= S_ROT;
              end
              default: begin
              end
            endcase
          end
        end
        S_ROT: begin
          step <= step + IDX_W'(1);
          hits <= hits_next;
          if (hit && !found) begin
            found <= 1'b1;
            first <= step;
          end
          if ((op == OP_READ) && (step == pos)) rd <= cw[0];
          if (last) begin
            if (op == OP_READ) begin
              state <= S_DONE;
            end else if (hits_next == '0) begin
              st    <= ST_MISSING;
              state <= S_DONE;
            end else begin
              state <= S_MARK;
            end
          end
        end
        S_MARK: begin
          step  <= '0;
          state <= S_SWAP;
        end
        S_SWAP: begin
          step <= step + IDX_W'(1);
          if (last) begin
            elem_cnt <= cnt_next;
            cap_reg  <= cap_shrink(cap_reg, cnt_next);
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            count     <= elem_cnt;
            capacity  <= cap_reg;
            read_word <= rd;
            status    <= st;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_le_cap: assert property (@(posedge clk) disable iff (rst) elem_cnt <= cap_reg)
    else $error("count exceeds capacity");
  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    cap_reg != '0 && cap_reg <= CNT_W'(DEPTH))
    else $error("capacity out of range");
  a_one_item: assert property (@(posedge clk) disable iff (rst) acc |=> !in_ready)
    else $error("second transfer while busy");
`endif
endmodule

// ===== bench/testbench.sv =====
// Testbench for the compacting array table: directed table, a fill to full, then random operations.
`timescale 1ns / 1ps
module testbench;
  import cat_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] val;
    logic [7:0]  pos;
    logic [8:0]  amt;
    bit          fixed;
    logic [8:0]  e_cnt;
    logic [8:0]  e_cap;
    logic [31:0] e_rd;
    logic [2:0]  e_st;
  } row_t;

  typedef struct {
    logic [8:0]  cnt;
    logic [8:0]  cap;
    logic [31:0] rd;
    logic [2:0]  st;
  } outcome_t;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic signed [31:0] value = '0;
  logic [7:0] position = '0;
  logic [8:0] amount = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [8:0] count, capacity;
  logic signed [31:0] read_word;
  logic [2:0] status;

  compacting_array_table dut (.*);

  always #4 clk = ~clk;

  logic [31:0] shadow_words[$];
  int unsigned shadow_cap = 1;
  outcome_t pending_outcomes[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int calm = 0;
  int hold_off = 0;
  int op_hits[8];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic void apply_shrink();
    if (shadow_cap >= 4 * shadow_words.size()) begin
      shadow_cap = shadow_cap / 2;
      if (shadow_cap < 1) shadow_cap = 1;
    end
  endfunction

  function automatic outcome_t predict_table(input logic [2:0] op, input logic [31:0] val,
                                             input logic [7:0] pos, input logic [8:0] amt);
    outcome_t r;
    int n;
    logic [31:0] kept[$];
    r.rd = '0;
    r.st = ST_OK;
    n = shadow_words.size();
    case (op)
      OP_APPEND: begin
        if (n >= DEPTH) r.st = ST_FULL;
        else begin
          if (n >= shadow_cap) shadow_cap = (shadow_cap * 2 > DEPTH) ? DEPTH : shadow_cap * 2;
          shadow_words.push_back(val);
        end
      end
      OP_POP: begin
        if (amt > n) r.st = ST_POP;
        else begin
          repeat (amt) shadow_words.delete(shadow_words.size() - 1);
          apply_shrink();
        end
      end
      OP_DEL_IDX: begin
        if (pos >= n) r.st = ST_INDEX;
        else begin
          shadow_words.delete(pos);
          apply_shrink();
        end
      end
      OP_DEL_FIRST: begin
        r.st = ST_MISSING;
        for (int i = 0; i < n; i++) begin
          if (shadow_words[i] == val) begin
            shadow_words.delete(i);
            r.st = ST_OK;
            apply_shrink();
            break;
          end
        end
      end
      OP_DEL_ALL: begin
        foreach (shadow_words[i]) if (shadow_words[i] != val) kept.push_back(shadow_words[i]);
        if (kept.size() == n) r.st = ST_MISSING;
        else begin
          shadow_words = kept;
          apply_shrink();
        end
      end
      OP_READ: begin
        if (pos >= n) r.st = ST_INDEX;
        else r.rd = shadow_words[pos];
      end
      default: ;
    endcase
    r.cnt = 9'(shadow_words.size());
    r.cap = 9'(shadow_cap);
    return r;
  endfunction

  task automatic send_item(input row_t rw);
    outcome_t o;
    while (calm == 0 && $urandom_range(99) < 36) begin
      in_valid <= 0;
      @(negedge clk);
    end
    operation <= rw.op;
    value     <= rw.val;
    position  <= rw.pos;
    amount    <= rw.amt;
    in_valid  <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    o = predict_table(rw.op, rw.val, rw.pos, rw.amt);
    if (rw.fixed && (o.cnt !== rw.e_cnt || o.cap !== rw.e_cap || o.rd !== rw.e_rd ||
                     o.st !== rw.e_st)) begin
      $display("table row %0d disagrees with prediction", items_sent);
      errors++;
    end
    pending_outcomes.push_back(o);
    op_hits[rw.op]++;
    items_sent++;
    @(negedge clk);
  endtask

  function automatic row_t mk(input logic [2:0] op, input logic [31:0] val, input logic [7:0] pos,
                              input logic [8:0] amt);
    row_t r;
    r.op = op; r.val = val; r.pos = pos; r.amt = amt; r.fixed = 0;
    r.e_cnt = 0; r.e_cap = 0; r.e_rd = 0; r.e_st = 0;
    return r;
  endfunction

  function automatic row_t mkx(input logic [2:0] op, input logic [31:0] val, input logic [7:0] pos,
                               input logic [8:0] amt, input logic [8:0] ec, input logic [8:0] ek,
                               input logic [31:0] er, input logic [2:0] es);
    row_t r;
    r = mk(op, val, pos, amt);
    r.fixed = 1; r.e_cnt = ec; r.e_cap = ek; r.e_rd = er; r.e_st = es;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(5);
    endcase
  endfunction

  // receiver
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 0;
      hold_off <= hold_off - 1;
    end else out_ready <= (calm != 0) || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        outcome_t e;
        e = pending_outcomes.pop_front();
        if (count !== e.cnt) report("count", count, e.cnt);
        if (capacity !== e.cap) report("capacity", capacity, e.cap);
        if (read_word !== e.rd) report("read_word", read_word, e.rd);
        if (status !== e.st) report("status", status, e.st);
      end
      results_seen++;
    end
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    row_t plan[$];
    row_t rw;
    int r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    plan.push_back(mkx(OP_READ, 0, 0, 0, 0, 1, 0, ST_INDEX));
    plan.push_back(mkx(OP_POP, 0, 0, 1, 0, 1, 0, ST_POP));
    plan.push_back(mkx(OP_DEL_IDX, 0, 0, 0, 0, 1, 0, ST_INDEX));
    plan.push_back(mkx(OP_DEL_FIRST, 5, 0, 0, 0, 1, 0, ST_MISSING));
    plan.push_back(mkx(OP_DEL_ALL, 5, 0, 0, 0, 1, 0, ST_MISSING));
    plan.push_back(mkx(OP_POP, 0, 0, 0, 0, 1, 0, ST_OK));
    plan.push_back(mkx(OP_APPEND, 32'h8000_0000, 0, 0, 1, 1, 0, ST_OK));
    plan.push_back(mkx(OP_APPEND, 32'h7fff_ffff, 0, 0, 2, 2, 0, ST_OK));
    plan.push_back(mkx(OP_APPEND, 32'hffff_ffff, 0, 0, 3, 4, 0, ST_OK));
    plan.push_back(mkx(OP_READ, 0, 0, 0, 3, 4, 32'h8000_0000, ST_OK));
    plan.push_back(mkx(OP_READ, 0, 1, 0, 3, 4, 32'h7fff_ffff, ST_OK));
    plan.push_back(mkx(OP_READ, 0, 255, 0, 3, 4, 0, ST_INDEX));
    plan.push_back(mk(OP_APPEND, 32'hffff_ffff, 0, 0));
    plan.push_back(mk(OP_DEL_ALL, 32'hffff_ffff, 0, 0));
    plan.push_back(mk(OP_DEL_FIRST, 32'h7fff_ffff, 0, 0));
    plan.push_back(mk(OP_DEL_IDX, 0, 0, 0));
    plan.push_back(mkx(OP_SPARE6, 0, 0, 0, 0, 1, 0, ST_OK));
    plan.push_back(mkx(OP_SPARE7, 32'hffff_ffff, 8'hff, 9'h1ff, 0, 1, 0, ST_OK));
    plan.push_back(mkx(OP_POP, 0, 0, 9'h100, 0, 1, 0, ST_POP));
    foreach (plan[i]) send_item(plan[i]);

    // fill to the top and bounce off full; receiver stalls for a long stretch meanwhile
    calm = 1;
    hold_off = 400;
    for (int i = 0; i < 257; i++) send_item(mk(OP_APPEND, $urandom, 8'($urandom), 9'($urandom)));
    calm = 0;
    send_item(mk(OP_READ, 0, 255, 0));
    send_item(mk(OP_DEL_IDX, 0, 255, 0));
    send_item(mk(OP_DEL_IDX, 0, 0, 0));
    send_item(mk(OP_POP, 0, 0, 9'd254));

    // random part: appends dominate so deletes find real content
    for (int i = 0; i < 560; i++) begin
      r = $urandom_range(99);
      if (r < 40) rw = mk(OP_APPEND, pick_word(), 0, 0);
      else if (r < 48) rw = mk(OP_POP, 0, 0, 9'($urandom_range(3) == 0 ? $urandom :
                                 $urandom_range(shadow_words.size())));
      else if (r < 60) rw = mk(OP_DEL_IDX, 0, 8'($urandom_range(3) == 0 ? $urandom :
                                 $urandom_range(shadow_words.size())), 0);
      else if (r < 72) rw = mk(OP_DEL_FIRST, pick_word(), 0, 0);
      else if (r < 80) rw = mk(OP_DEL_ALL, pick_word(), 0, 0);
      else if (r < 97) rw = mk(OP_READ, 0, 8'($urandom_range(3) == 0 ? $urandom :
                                 $urandom_range(shadow_words.size())), 0);
      else rw = mk(3'($urandom_range(7, 6)), $urandom, 8'($urandom), 9'($urandom));
      if (rw.op == OP_DEL_FIRST && shadow_words.size() > 0 && $urandom_range(1))
        rw.val = shadow_words[$urandom_range(shadow_words.size() - 1)];
      send_item(rw);
    end
    in_valid <= 0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("%0d items sent, %0d results checked; ops by code: %0d %0d %0d %0d %0d %0d",
             items_sent, results_seen, op_hits[0], op_hits[1], op_hits[2], op_hits[3],
             op_hits[4], op_hits[5]);
    $display("table filled to the top with a long output stall; spare codes %0d",
             op_hits[6] + op_hits[7]);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
